>>> design/hsv_to_rgb_pixel_unit_macros.svh
// assertion helpers shared by the pixel unit
`ifndef HSV_TO_RGB_PIXEL_UNIT_MACROS_SVH
`define HSV_TO_RGB_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define HSV_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("hsv pixel unit: same-cycle check failed");

// next-cycle implication, off while reset is low
`define HSV_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("hsv pixel unit: next-cycle check failed");

`endif

>>> design/hsv_pkg.sv
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned HUE_W  = 11;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SEXT_W = 3;

  localparam logic [HUE_W-1:0]  HUE_SPAN   = 11'd1536;
  localparam logic [SEXT_W-1:0] SEXT_COUNT = 3'd6;

  // sextant in which each channel ramps up
  localparam logic [SEXT_W-1:0] RED_RISE   = 3'd4;
  localparam logic [SEXT_W-1:0] GREEN_RISE = 3'd0;
  localparam logic [SEXT_W-1:0] BLUE_RISE  = 3'd2;

  localparam logic [CHAN_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [CHAN_W-1:0] LEVEL_ZERO = 8'd0;

  // load enables for the stages held inside each channel slice
  typedef struct packed {
    logic ld2;
    logic ld3;
  } hsv_ctl_t;

  // ramp level of one channel for a given sextant and position
  function automatic logic [CHAN_W-1:0] chan_level(
    input logic [SEXT_W-1:0] sextant,
    input logic [CHAN_W-1:0] pos,
    input logic [SEXT_W-1:0] rise
  );
    logic [SEXT_W-1:0] rel;
    logic [CHAN_W-1:0] lvl;
    if (sextant >= rise) begin
      rel = sextant - rise;
    end else begin
      rel = sextant + SEXT_COUNT - rise;
    end
    case (rel)
      3'd0:    lvl = pos;
      3'd1:    lvl = LEVEL_FULL;
      3'd2:    lvl = LEVEL_FULL;
      3'd3:    lvl = LEVEL_FULL - pos;
      default: lvl = LEVEL_ZERO;
    endcase
    return lvl;
  endfunction

endpackage

>>> design/hsv_to_rgb_pixel_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                         | tuser
// in_     | in  | hue[10:0] sat[18:11] brightness[26:19] pad | -
// out_    | out | red[7:0] green[15:8] blue[23:16]           | hue_wrapped
//
// three register stages: ramp level, brightness scale, saturation blend
// one pixel per cycle sustained while out_tready stays high
// each stage loads when it is empty or the one after it moves, so bubbles close
// a stall on out_tready holds the output stage and every full stage packed behind it
// rst_n clears the stage valid bits only, payload registers are not reset

module hsv_to_rgb_pixel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[10:0], saturation[18:11], brightness[26:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic        out_tuser   // hue_wrapped
);
  import hsv_pkg::*;

`include "hsv_to_rgb_pixel_unit_macros.svh"

  // input field split
  logic [HUE_W-1:0]  in_hue;
  logic [CHAN_W-1:0] in_sat;
  logic [CHAN_W-1:0] in_val;

  assign in_hue = in_tdata[10:0];
  assign in_sat = in_tdata[18:11];
  assign in_val = in_tdata[26:19];

  // stage valids
  logic v1_r, v2_r, v3_r;
  logic ld1;
  hsv_ctl_t ctl;

  always_comb begin
    ctl.ld3 = !v3_r || out_tready;
    ctl.ld2 = !v2_r || ctl.ld3;
    ld1     = !v1_r || ctl.ld2;
  end

  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_tvalid;
      end
      if (ctl.ld2) begin
        v2_r <= v1_r;
      end
      if (ctl.ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  // stage 1: hue wrap, sextant split, per-channel ramp level
  logic              wrap_nxt;
  logic [HUE_W-1:0]  hue_w;
  logic [SEXT_W-1:0] sextant;
  logic [CHAN_W-1:0] pos;
  logic [CHAN_W-1:0] red_lvl_nxt, green_lvl_nxt, blue_lvl_nxt;

  always_comb begin
    wrap_nxt = (in_hue >= HUE_SPAN);
    hue_w    = wrap_nxt ? (in_hue - HUE_SPAN) : in_hue;
    sextant  = hue_w[HUE_W-1:CHAN_W];
    pos      = hue_w[CHAN_W-1:0];
    red_lvl_nxt   = chan_level(sextant, pos, RED_RISE);
    green_lvl_nxt = chan_level(sextant, pos, GREEN_RISE);
    blue_lvl_nxt  = chan_level(sextant, pos, BLUE_RISE);
  end

  logic [CHAN_W-1:0] red_lvl_r, green_lvl_r, blue_lvl_r;
  logic [CHAN_W-1:0] sat1_r, val1_r, sat2_r, val2_r;
  logic              wrap1_r, wrap2_r, wrap3_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      red_lvl_r   <= red_lvl_nxt;
      green_lvl_r <= green_lvl_nxt;
      blue_lvl_r  <= blue_lvl_nxt;
      sat1_r      <= in_sat;
      val1_r      <= in_val;
      wrap1_r     <= wrap_nxt;
    end
    if (ctl.ld2) begin
      sat2_r  <= sat1_r;
      val2_r  <= val1_r;
      wrap2_r <= wrap1_r;
    end
    if (ctl.ld3) begin
      wrap3_r <= wrap2_r;
    end
  end

  // stages 2 and 3 live in the channel slices
  logic [CHAN_W-1:0] red, green, blue;

  hsv_chan u_red (
    .clk    (clk),
    .ctl    (ctl),
    .level  (red_lvl_r),
    .val_s1 (val1_r),
    .val_s2 (val2_r),
    .sat_s2 (sat2_r),
    .result (red)
  );

  hsv_chan u_green (
    .clk    (clk),
    .ctl    (ctl),
    .level  (green_lvl_r),
    .val_s1 (val1_r),
    .val_s2 (val2_r),
    .sat_s2 (sat2_r),
    .result (green)
  );

  hsv_chan u_blue (
    .clk    (clk),
    .ctl    (ctl),
    .level  (blue_lvl_r),
    .val_s1 (val1_r),
    .val_s2 (val2_r),
    .sat_s2 (sat2_r),
    .result (blue)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {blue, green, red};
  assign out_tuser  = wrap3_r;

  // an empty output stage never blocks the input
  `HSV_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !out_tvalid, in_tready)
  // an input transfer always lands in stage 1
  `HSV_ASSERT_NXT(a_in_lands_s1, clk, rst_n, in_tvalid && in_tready, v1_r)
  // a full stage 2 that moves shows up at the output
  `HSV_ASSERT_NXT(a_s2_reaches_out, clk, rst_n, v2_r && ctl.ld3, out_tvalid)
  // a full stage 1 that moves fills stage 2
  `HSV_ASSERT_NXT(a_s1_reaches_s2, clk, rst_n, v1_r && ctl.ld2, v2_r)

endmodule

>>> design/hsv_chan.sv
`timescale 1ns / 1ps

module hsv_chan (
  input  logic                        clk,
  input  hsv_pkg::hsv_ctl_t           ctl,
  input  logic [hsv_pkg::CHAN_W-1:0]  level,
  input  logic [hsv_pkg::CHAN_W-1:0]  val_s1,
  input  logic [hsv_pkg::CHAN_W-1:0]  val_s2,
  input  logic [hsv_pkg::CHAN_W-1:0]  sat_s2,
  output logic [hsv_pkg::CHAN_W-1:0]  result
);
  import hsv_pkg::*;

  logic [2*CHAN_W-1:0] scaled_prod;
  logic [CHAN_W-1:0]   x_nxt;
  logic [CHAN_W-1:0]   x_r;
  logic [CHAN_W-1:0]   diff;
  logic [2*CHAN_W-1:0] sat_prod;
  logic [CHAN_W-1:0]   res_nxt;
  logic [CHAN_W-1:0]   res_r;

  // level scaled by brightness, truncated
  always_comb begin
    scaled_prod = level * val_s1;
    x_nxt       = scaled_prod[2*CHAN_W-1:CHAN_W];
  end

  // blend from brightness toward x by saturation; x never exceeds brightness
  always_comb begin
    diff     = val_s2 - x_r;
    sat_prod = diff * sat_s2;
    res_nxt  = val_s2 - sat_prod[2*CHAN_W-1:CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      x_r <= x_nxt;
    end
    if (ctl.ld3) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule
